>>> rtl/core/rti_pkg.sv
package rti_pkg;

  localparam int FIELD_W         = 32;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int MUL_LIMB        = 32;
  localparam int MUL_LAT         = 3;
  localparam int WEIGHT_BITS     = 16;

  localparam logic [WEIGHT_BITS:0] WEIGHT_ONE      = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
  localparam logic [FIELD_W-1:0]   DIR_Z_RESET     = 32'h0001_0000;
  localparam logic [FIELD_W-1:0]   THRESHOLD_RESET = 32'h0000_0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_DIR_X     = 3'd3,
    CFG_DIR_Y     = 3'd4,
    CFG_DIR_Z     = 3'd5,
    CFG_THRESHOLD = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vert_a_x;
    logic signed [FIELD_W-1:0] vert_a_y;
    logic signed [FIELD_W-1:0] vert_a_z;
    logic signed [FIELD_W-1:0] vert_b_x;
    logic signed [FIELD_W-1:0] vert_b_y;
    logic signed [FIELD_W-1:0] vert_b_z;
    logic signed [FIELD_W-1:0] vert_c_x;
    logic signed [FIELD_W-1:0] vert_c_y;
    logic signed [FIELD_W-1:0] vert_c_z;
  } rti_req_t;

  typedef struct packed {
    logic                   hit;
    logic [WEIGHT_BITS:0]   bary_u;
    logic [WEIGHT_BITS:0]   bary_v;
  } rti_rsp_t;

endpackage

>>> rtl/core/rti_mul.sv
module rti_mul import rti_pkg::*; #(
  parameter int WA = COORD_WIDTH_DEF,
  parameter int WB = COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int LW = MUL_LIMB;
  localparam int NA = (WA + LW - 1) / LW;
  localparam int NB = (WB + LW - 1) / LW;
  localparam int XA = NA * LW;
  localparam int XB = NB * LW;
  localparam int PW = WA + WB;
  localparam int AW = PW + 2 * LW + 2;

  logic signed [XA-1:0]     a_x;
  logic signed [XB-1:0]     b_x;
  logic signed [LW:0]       la [NA];
  logic signed [LW:0]       lb [NB];
  logic signed [2*LW+1:0]   pp [NA][NB];
  logic signed [AW-1:0]     row_c [NA];
  logic signed [AW-1:0]     row_r [NA];
  logic signed [AW-1:0]     acc;

  assign a_x = XA'(a);
  assign b_x = XB'(b);

  // top limb carries the sign, lower limbs are unsigned
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      la[i] = {(i == NA - 1) ? a_x[XA-1] : 1'b0, a_x[i*LW +: LW]};
    end
    for (int j = 0; j < NB; j++) begin
      lb[j] = {(j == NB - 1) ? b_x[XB-1] : 1'b0, b_x[j*LW +: LW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= la[i] * lb[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_c[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_c[i] = row_c[i] + (AW'(pp[i][j]) <<< (j * LW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_c;
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + (row_r[i] <<< (i * LW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[PW-1:0];
    end
  end

endmodule

>>> rtl/core/rti_delay.sv
module rti_delay import rti_pkg::*; #(
  parameter int W     = COORD_WIDTH_DEF,
  parameter int DEPTH = MUL_LAT
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

>>> rtl/core/rti_div.sv
module rti_div import rti_pkg::*; #(
  parameter int RW = 2 * COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RW-1:0]        num,
  input  logic [RW-1:0]        den,
  output logic [WEIGHT_BITS:0] quot
);

  localparam int STEPS = WEIGHT_BITS;

  logic [RW-1:0]    a_r [0:STEPS];
  logic [RW-1:0]    b_r [0:STEPS];
  logic [STEPS-1:0] q_r [0:STEPS];
  logic             sat_r [0:STEPS];
  logic [RW-1:0]    sh [1:STEPS];
  logic             ge [1:STEPS];

  // one restoring step per stage
  always_comb begin
    for (int s = 1; s <= STEPS; s++) begin
      sh[s] = {a_r[s-1][RW-2:0], 1'b0};
      ge[s] = (sh[s] >= b_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= num;
      b_r[0]   <= den;
      q_r[0]   <= '0;
      sat_r[0] <= (num >= den);
      for (int s = 1; s <= STEPS; s++) begin
        a_r[s]   <= ge[s] ? (sh[s] - b_r[s-1]) : sh[s];
        b_r[s]   <= b_r[s-1];
        q_r[s]   <= {q_r[s-1][STEPS-2:0], ge[s]};
        sat_r[s] <= sat_r[s-1];
      end
    end
  end

  assign quot = sat_r[STEPS] ? WEIGHT_ONE : {1'b0, q_r[STEPS]};

endmodule

>>> rtl/core/ray_triangle_intersect_unit.sv
// ray / triangle intersection unit
// one ray (origin, direction, parallel threshold) sits in configuration
// registers written through cfg_we / cfg_index / cfg_data; write them only
// while no request is in flight. each request on req_* carries the three
// vertices of one triangle; each produces exactly one response on rsp_*
// with the hit flag and two barycentric weights (zero on a miss).
// the datapath is a fixed pipeline of 39 register stages: five rounds of
// pipelined limb multipliers with an add stage after each, then a 17-stage
// restoring divider per weight. the last stage feeds the output register;
// one request per cycle is taken in steady state while req_stall is low.
// the output register is backed by one skid entry. when the receiver holds
// rsp_stall the pipeline keeps running until a response lands in the skid
// entry; from then req_stall is high and every stage holds its contents.
// synchronous reset clears all valid bits, the skid entry and the
// configuration registers (origin 0, direction (0,0,1.0), threshold 1).
module ray_triangle_intersect_unit import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  rti_req_t             req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rti_rsp_t             rsp_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int NW   = 2 * EW + 1;
  localparam int DW   = NW + CW + 2;
  localparam int UW   = NW + EW + 2;
  localparam int NNW  = 2 * NW + 2;
  localparam int QW   = DW + EW + 1;
  localparam int XW   = EW + QW + 1;
  localparam int TW   = NW + XW + 2;
  localparam int DENW = DW + 1 + NNW;
  localparam int RW   = ((TW > DENW) ? TW : DENW) + 1;

  localparam int S_E   = 1;
  localparam int S_N   = S_E + MUL_LAT + 1;
  localparam int S_DOT = S_N + MUL_LAT + 1;
  localparam int S_ABS = S_DOT + 1;
  localparam int S_Q   = S_DOT + MUL_LAT + 1;
  localparam int S_DEN = S_ABS + MUL_LAT;
  localparam int S_X   = S_Q + MUL_LAT + 1;
  localparam int S_W   = S_X + MUL_LAT + 1;
  localparam int S_HIT = S_W + 1;
  localparam int S_OUT = S_HIT + WEIGHT_BITS + 1;

  logic [FIELD_W-1:0] org_r [3];
  logic [FIELD_W-1:0] dir_r [3];
  logic [FIELD_W-1:0] thr_r;

  logic                en;
  logic [S_OUT-1:0]    vld;
  logic                skid_v;
  rti_rsp_t            skid_d;
  rti_rsp_t            pipe_d;
  logic                pipe_v;

  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];

  logic signed [EW-1:0] e_ac1 [3];
  logic signed [EW-1:0] ao1 [3];
  logic signed [EW-1:0] ao5 [3];
  logic signed [EW-1:0] ed1 [3][3];
  logic signed [EW-1:0] ov1 [3][3];
  logic signed [EW-1:0] ed13 [3][3];
  logic signed [EW-1:0] ov9 [3][3];

  logic signed [2*EW-1:0]    np0 [3];
  logic signed [2*EW-1:0]    np1 [3];
  logic signed [NW-1:0]      n5 [3];
  logic signed [NW-1:0]      n17 [3];
  logic signed [NW+CW-1:0]   pd [3];
  logic signed [NW+EW-1:0]   pu [3];
  logic signed [2*NW-1:0]    pn [3];
  logic signed [DW-1:0]      d9;
  logic signed [UW-1:0]      u9;
  logic signed [NNW-1:0]     nn9;
  logic signed [NNW-1:0]     nn10;
  logic signed [DW:0]        dabs_c;
  logic signed [DW:0]        dabs10;
  logic                      dneg10;
  logic                      miss10;
  logic [1:0]                flags21;
  logic signed [DW+EW-1:0]   pq [3][3];
  logic signed [UW+CW-1:0]   pdn [3];
  logic signed [QW-1:0]      q13 [3][3];
  logic signed [DENW-1:0]    pden;
  logic [DENW-1:0]           den22;
  logic signed [EW+QW-1:0]   px0 [3][3];
  logic signed [EW+QW-1:0]   px1 [3][3];
  logic signed [XW-1:0]      x17 [3][3];
  logic signed [NW+XW-1:0]   pw [3][3];
  logic signed [TW-1:0]      w21 [3];
  logic signed [TW-1:0]      wfix [3];
  logic                      wneg [3];
  logic                      hit22;
  logic [RW-1:0]             mag_u22;
  logic [RW-1:0]             mag_v22;
  logic                      hit39;
  logic [WEIGHT_BITS:0]      qu;
  logic [WEIGHT_BITS:0]      qv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RESET;
      thr_r    <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X:  org_r[0] <= cfg_data;
        CFG_ORIGIN_Y:  org_r[1] <= cfg_data;
        CFG_ORIGIN_Z:  org_r[2] <= cfg_data;
        CFG_DIR_X:     dir_r[0] <= cfg_data;
        CFG_DIR_Y:     dir_r[1] <= cfg_data;
        CFG_DIR_Z:     dir_r[2] <= cfg_data;
        CFG_THRESHOLD: thr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !skid_v;
  assign req_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-2:0], req_valid};
    end
  end

  always_comb begin
    va[0] = $signed(req_data.vert_a_x[CW-1:0]);
    va[1] = $signed(req_data.vert_a_y[CW-1:0]);
    va[2] = $signed(req_data.vert_a_z[CW-1:0]);
    vb[0] = $signed(req_data.vert_b_x[CW-1:0]);
    vb[1] = $signed(req_data.vert_b_y[CW-1:0]);
    vb[2] = $signed(req_data.vert_b_z[CW-1:0]);
    vc[0] = $signed(req_data.vert_c_x[CW-1:0]);
    vc[1] = $signed(req_data.vert_c_y[CW-1:0]);
    vc[2] = $signed(req_data.vert_c_z[CW-1:0]);
    for (int c = 0; c < 3; c++) begin
      org[c] = $signed(org_r[c][CW-1:0]);
      dir[c] = $signed(dir_r[c][CW-1:0]);
    end
  end

  // edges and vertex offsets
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ed1[0][c] <= EW'(vb[c]) - EW'(va[c]);
        ed1[1][c] <= EW'(vc[c]) - EW'(vb[c]);
        ed1[2][c] <= EW'(va[c]) - EW'(vc[c]);
        e_ac1[c]  <= EW'(vc[c]) - EW'(va[c]);
        ao1[c]    <= EW'(va[c]) - EW'(org[c]);
        ov1[0][c] <= EW'(org[c]) - EW'(va[c]);
        ov1[1][c] <= EW'(org[c]) - EW'(vb[c]);
        ov1[2][c] <= EW'(org[c]) - EW'(vc[c]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dly_kc
    for (genvar c = 0; c < 3; c++) begin : g_c
      rti_delay #(.W(EW), .DEPTH(S_DOT - S_E)) u_ov (
        .clk, .en, .d(ov1[k][c]), .q(ov9[k][c])
      );
      rti_delay #(.W(EW), .DEPTH(S_Q - S_E)) u_ed (
        .clk, .en, .d(ed1[k][c]), .q(ed13[k][c])
      );
    end
  end

  // face normal
  for (genvar c = 0; c < 3; c++) begin : g_norm
    localparam int C1 = (c + 1) % 3;
    localparam int C2 = (c + 2) % 3;
    rti_mul #(.WA(EW), .WB(EW)) u_m0 (
      .clk, .en, .a(ed1[0][C1]), .b(e_ac1[C2]), .p(np0[c])
    );
    rti_mul #(.WA(EW), .WB(EW)) u_m1 (
      .clk, .en, .a(ed1[0][C2]), .b(e_ac1[C1]), .p(np1[c])
    );
    rti_delay #(.W(EW), .DEPTH(S_N - S_E)) u_ao (
      .clk, .en, .d(ao1[c]), .q(ao5[c])
    );
    rti_delay #(.W(NW), .DEPTH(S_X - S_N)) u_n (
      .clk, .en, .d(n5[c]), .q(n17[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        n5[c] <= NW'(np0[c]) - NW'(np1[c]);
      end
    end
  end

  // dot products with the normal
  for (genvar c = 0; c < 3; c++) begin : g_dot
    rti_mul #(.WA(NW), .WB(CW)) u_d (
      .clk, .en, .a(n5[c]), .b(dir[c]), .p(pd[c])
    );
    rti_mul #(.WA(NW), .WB(EW)) u_u (
      .clk, .en, .a(n5[c]), .b(ao5[c]), .p(pu[c])
    );
    rti_mul #(.WA(NW), .WB(NW)) u_nn (
      .clk, .en, .a(n5[c]), .b(n5[c]), .p(pn[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d9  <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
      u9  <= UW'(pu[0]) + UW'(pu[1]) + UW'(pu[2]);
      nn9 <= NNW'(pn[0]) + NNW'(pn[1]) + NNW'(pn[2]);
    end
  end

  // parallel and behind-origin rejection
  assign dabs_c = d9[DW-1] ? -(DW+1)'(d9) : (DW+1)'(d9);

  always_ff @(posedge clk) begin
    if (en) begin
      dabs10 <= dabs_c;
      dneg10 <= d9[DW-1];
      miss10 <= (d9 == '0) || ($unsigned(dabs_c) < (DW+1)'(thr_r))
                || ((u9 != '0) && (u9[UW-1] != d9[DW-1]));
    end
  end

  rti_delay #(.W(NNW), .DEPTH(S_ABS - S_DOT)) u_nn_dly (
    .clk, .en, .d(nn9), .q(nn10)
  );

  rti_delay #(.W(2), .DEPTH(S_W - S_ABS)) u_flag_dly (
    .clk, .en, .d({dneg10, miss10}), .q(flags21)
  );

  rti_mul #(.WA(DW + 1), .WB(NNW)) u_den (
    .clk, .en, .a(dabs10), .b(nn10), .p(pden)
  );

  rti_delay #(.W(DENW), .DEPTH(S_HIT - S_DEN)) u_den_dly (
    .clk, .en, .d(pden), .q(den22)
  );

  // hit point scaled by N.dir, per vertex
  for (genvar c = 0; c < 3; c++) begin : g_q
    rti_mul #(.WA(CW), .WB(UW)) u_dn (
      .clk, .en, .a(dir[c]), .b(u9), .p(pdn[c])
    );
    for (genvar k = 0; k < 3; k++) begin : g_k
      rti_mul #(.WA(DW), .WB(EW)) u_dov (
        .clk, .en, .a(d9), .b(ov9[k][c]), .p(pq[k][c])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          q13[k][c] <= QW'(pq[k][c]) + QW'(pdn[c]);
        end
      end
    end
  end

  // edge cross products
  for (genvar k = 0; k < 3; k++) begin : g_x
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      rti_mul #(.WA(EW), .WB(QW)) u_x0 (
        .clk, .en, .a(ed13[k][C1]), .b(q13[k][C2]), .p(px0[k][c])
      );
      rti_mul #(.WA(EW), .WB(QW)) u_x1 (
        .clk, .en, .a(ed13[k][C2]), .b(q13[k][C1]), .p(px1[k][c])
      );
      rti_mul #(.WA(NW), .WB(XW)) u_w (
        .clk, .en, .a(n17[c]), .b(x17[k][c]), .p(pw[k][c])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          x17[k][c] <= XW'(px0[k][c]) - XW'(px1[k][c]);
        end
        w21[k] <= TW'(pw[k][0]) + TW'(pw[k][1]) + TW'(pw[k][2]);
      end
    end
  end

  // edge tests and weight magnitudes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wneg[k] = (w21[k] != '0) && (w21[k][TW-1] != flags21[1]);
      wfix[k] = flags21[1] ? -w21[k] : w21[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit22   <= !flags21[0] && !wneg[0] && !wneg[1] && !wneg[2];
      mag_u22 <= {{(RW-TW){1'b0}}, wfix[1]};
      mag_v22 <= {{(RW-TW){1'b0}}, wfix[2]};
    end
  end

  rti_div #(.RW(RW)) u_div_u (
    .clk, .en, .num(mag_u22), .den({{(RW-DENW){1'b0}}, den22}), .quot(qu)
  );

  rti_div #(.RW(RW)) u_div_v (
    .clk, .en, .num(mag_v22), .den({{(RW-DENW){1'b0}}, den22}), .quot(qv)
  );

  rti_delay #(.W(1), .DEPTH(S_OUT - S_HIT)) u_hit_dly (
    .clk, .en, .d(hit22), .q(hit39)
  );

  always_comb begin
    pipe_v        = vld[S_OUT-1];
    pipe_d.hit    = hit39;
    pipe_d.bary_u = hit39 ? qu : '0;
    pipe_d.bary_v = hit39 ? qv : '0;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_v) begin
        rsp_valid <= 1'b1;
        rsp_data  <= skid_d;
        skid_v    <= 1'b0;
      end else begin
        rsp_valid <= pipe_v;
        rsp_data  <= pipe_d;
      end
    end else if (pipe_v && en) begin
      skid_v <= 1'b1;
      skid_d <= pipe_d;
    end
  end

endmodule

>>> rtl/core/rti_checker.sv
module rti_checker import rti_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input rti_rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.hit |-> rsp_data.bary_u == '0 && rsp_data.bary_v == '0)
    else $error("miss with nonzero weights");

  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.bary_u <= WEIGHT_ONE && rsp_data.bary_v <= WEIGHT_ONE)
    else $error("weight above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
    else $error("request stall without a stalled response");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid && !req_stall)
    else $error("pipeline not empty after reset");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (.*);

>>> sim/ray_triangle_intersect_checker.sv
`timescale 1ns / 100ps

module ray_triangle_intersect_checker import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  rti_req_t             req_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rti_rsp_t             rsp_data,
  output int                   errors,
  output int                   pending
);

  typedef logic signed [319:0] wide_t;
  typedef struct {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec3_t;

  logic [FIELD_W-1:0] origin_x, origin_y, origin_z;
  logic [FIELD_W-1:0] dir_x, dir_y, dir_z;
  logic [FIELD_W-1:0] threshold;
  rti_rsp_t           hit_q[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic vec3_t vec(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                logic [FIELD_W-1:0] z);
    vec3_t r;
    r.x = wide_t'($signed(x));
    r.y = wide_t'($signed(y));
    r.z = wide_t'($signed(z));
    return r;
  endfunction

  function automatic vec3_t vsub(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t vcross(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(vec3_t a, vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // edge term scaled by n.dir: n . (e x (d*(org - v) + num*dir))
  function automatic wide_t edge_term(vec3_t n, vec3_t e, vec3_t v, vec3_t org,
                                      vec3_t dv, wide_t d, wide_t num);
    vec3_t q;
    q.x = d * (org.x - v.x) + num * dv.x;
    q.y = d * (org.y - v.y) + num * dv.y;
    q.z = d * (org.z - v.z) + num * dv.z;
    return vdot(n, vcross(e, q));
  endfunction

  function automatic bit opposite_sign(wide_t w, wide_t d);
    return (w != 0) && ((w < 0) != (d < 0));
  endfunction

  function automatic logic [WEIGHT_BITS:0] weight(wide_t w, wide_t den);
    wide_t q;
    if (w >= den) return WEIGHT_ONE;
    q = (w <<< WEIGHT_BITS) / den;
    return q[WEIGHT_BITS:0];
  endfunction

  function automatic rti_rsp_t predict_hit(rti_req_t r);
    vec3_t a, b, c, org, dv, eab, ebc, eca, n;
    wide_t d, dabs, num, wu, wv, den;
    rti_rsp_t res;
    res = '0;
    a = vec(r.vert_a_x, r.vert_a_y, r.vert_a_z);
    b = vec(r.vert_b_x, r.vert_b_y, r.vert_b_z);
    c = vec(r.vert_c_x, r.vert_c_y, r.vert_c_z);
    org = vec(origin_x, origin_y, origin_z);
    dv = vec(dir_x, dir_y, dir_z);
    eab = vsub(b, a);
    ebc = vsub(c, b);
    eca = vsub(a, c);
    n = vcross(eab, vsub(c, a));
    d = vdot(n, dv);
    dabs = (d < 0) ? -d : d;
    if (d == 0 || dabs < wide_t'({1'b0, threshold})) return res;
    num = vdot(n, vsub(a, org));
    if (opposite_sign(num, d)) return res;
    if (opposite_sign(edge_term(n, eab, a, org, dv, d, num), d)) return res;
    wu = edge_term(n, ebc, b, org, dv, d, num);
    if (opposite_sign(wu, d)) return res;
    wv = edge_term(n, eca, c, org, dv, d, num);
    if (opposite_sign(wv, d)) return res;
    if (d < 0) begin
      wu = -wu;
      wv = -wv;
    end
    den = dabs * vdot(n, n);
    res.hit = 1'b1;
    res.bary_u = weight(wu, den);
    res.bary_v = weight(wv, den);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= DIR_Z_RESET;
      threshold <= THRESHOLD_RESET;
      hit_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: origin_x <= cfg_data;
          CFG_ORIGIN_Y: origin_y <= cfg_data;
          CFG_ORIGIN_Z: origin_z <= cfg_data;
          CFG_DIR_X: dir_x <= cfg_data;
          CFG_DIR_Y: dir_y <= cfg_data;
          CFG_DIR_Z: dir_z <= cfg_data;
          CFG_THRESHOLD: threshold <= cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) hit_q.push_back(predict_hit(req_data));
      if (rsp_valid && !rsp_stall) begin
        if (hit_q.size() == 0) begin
          $display("%0t unexpected response: expected none, got %p", $time, rsp_data);
          errors++;
        end else begin
          rti_rsp_t exp_rsp;
          exp_rsp = hit_q.pop_front();
          if (rsp_data.hit !== exp_rsp.hit) begin
            $display("%0t hit: expected %0d, got %0d", $time, exp_rsp.hit, rsp_data.hit);
            errors++;
          end
          if (rsp_data.bary_u !== exp_rsp.bary_u) begin
            $display("%0t bary_u: expected %0d, got %0d", $time, exp_rsp.bary_u,
                     rsp_data.bary_u);
            errors++;
          end
          if (rsp_data.bary_v !== exp_rsp.bary_v) begin
            $display("%0t bary_v: expected %0d, got %0d", $time, exp_rsp.bary_v,
                     rsp_data.bary_v);
            errors++;
          end
        end
      end
    end
    pending = hit_q.size();
  end

endmodule

>>> sim/ray_triangle_intersect_unit_test.sv
`timescale 1ns / 100ps

module ray_triangle_intersect_unit_test;
  import rti_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;
  logic                 req_valid;
  logic                 req_stall;
  rti_req_t             req_data;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rti_rsp_t             rsp_data;
  int                   errors;
  int                   pending;

  int                   idle_cycles;
  bit                   hold_req;
  int                   burst_left;
  logic [FIELD_W-1:0]   ray_org[3];
  logic [FIELD_W-1:0]   ray_dir[3];

  ray_triangle_intersect_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

  ray_triangle_intersect_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    rsp_stall = 1'b0;
    mode = 0;
    mode_left = 100;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 400);
      end
      mode_left--;
      case (mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ray_triangle_intersect_unit_test: errors");
        $finish;
      end
    end
  end

  function automatic logic [FIELD_W-1:0] q16(int v);
    return FIELD_W'(v <<< 16);
  endfunction

  function automatic rti_req_t tri9(logic [FIELD_W-1:0] ax, logic [FIELD_W-1:0] ay,
                                    logic [FIELD_W-1:0] az, logic [FIELD_W-1:0] bx,
                                    logic [FIELD_W-1:0] by, logic [FIELD_W-1:0] bz,
                                    logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy,
                                    logic [FIELD_W-1:0] cz);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic set_ray(logic [FIELD_W-1:0] ox, logic [FIELD_W-1:0] oy,
                         logic [FIELD_W-1:0] oz, logic [FIELD_W-1:0] dx,
                         logic [FIELD_W-1:0] dy, logic [FIELD_W-1:0] dz,
                         logic [FIELD_W-1:0] th);
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_THRESHOLD, th);
    @(negedge clk);
    cfg_we <= 1'b0;
    ray_org = '{ox, oy, oz};
    ray_dir = '{dx, dy, dz};
  endtask

  task automatic send_triangle(rti_req_t t);
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req_data <= t;
    do @(posedge clk); while (req_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 50);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [FIELD_W-1:0] jitter(logic [FIELD_W-1:0] base, int spread_log);
    return base + FIELD_W'($urandom_range(0, (1 << spread_log) * 2)) - FIELD_W'(1 << spread_log);
  endfunction

  // vertices scattered around a point on the ray
  function automatic rti_req_t aimed_triangle();
    logic [FIELD_W-1:0] ctr[3];
    rti_req_t t;
    int k;
    int s;
    k = $urandom_range(0, 4);
    s = $urandom_range(4, 24);
    for (int i = 0; i < 3; i++) ctr[i] = ray_org[i] + FIELD_W'(k) * ray_dir[i];
    t = tri9(jitter(ctr[0], s), jitter(ctr[1], s), jitter(ctr[2], s),
             jitter(ctr[0], s), jitter(ctr[1], s), jitter(ctr[2], s),
             jitter(ctr[0], s), jitter(ctr[1], s), jitter(ctr[2], s));
    return t;
  endfunction

  function automatic rti_req_t random_triangle();
    rti_req_t t;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return aimed_triangle();
    t = tri9($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    if (pick == 9) begin
      // degenerate: repeated vertex
      t.vert_b_x = t.vert_a_x;
      t.vert_b_y = t.vert_a_y;
      t.vert_b_z = t.vert_a_z;
    end
    return t;
  endfunction

  task automatic random_phase(int count);
    int dz;
    logic [FIELD_W-1:0] th;
    dz = int'($urandom_range(0, 1 << 18)) - (1 << 17);
    if (dz > 65536) dz = 65536;
    th = ($urandom_range(0, 3) == 0) ? 32'd0 : FIELD_W'($urandom_range(0, 1 << 12));
    set_ray(jitter('0, 20), jitter('0, 20), jitter('0, 20),
            jitter('0, 17), jitter('0, 17), FIELD_W'(dz), th);
    repeat (count) send_triangle(random_triangle());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    ray_org = '{default: '0};
    ray_dir = '{'0, '0, DIR_Z_RESET};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset ray: origin 0, direction +z, threshold 1
    send_triangle(tri9(q16(-1), q16(-1), q16(2), q16(2), q16(-1), q16(2),
                       q16(-1), q16(2), q16(2)));
    send_triangle(tri9(q16(-1), q16(-1), q16(2), q16(-1), q16(2), q16(2),
                       q16(2), q16(-1), q16(2)));
    send_triangle(tri9(q16(-1), q16(-1), q16(-2), q16(2), q16(-1), q16(-2),
                       q16(-1), q16(2), q16(-2)));
    // origin on the plane
    send_triangle(tri9(q16(-1), q16(-1), 0, q16(2), q16(-1), 0, q16(-1), q16(2), 0));
    // ray through an edge, then through a vertex
    send_triangle(tri9(0, q16(-1), q16(1), 0, q16(1), q16(1), q16(2), 0, q16(1)));
    send_triangle(tri9(0, 0, q16(3), q16(2), 0, q16(3), 0, q16(2), q16(3)));
    // degenerate, collinear, parallel to the ray
    send_triangle(tri9(q16(1), q16(1), q16(1), q16(1), q16(1), q16(1),
                       q16(1), q16(1), q16(1)));
    send_triangle(tri9(0, 0, 0, q16(1), q16(1), q16(1), q16(2), q16(2), q16(2)));
    send_triangle(tri9(0, 0, 0, q16(1), 0, 0, 0, 0, q16(1)));
    // miss beside, and a small hit near a vertex for skewed weights
    send_triangle(tri9(q16(5), q16(5), q16(1), q16(6), q16(5), q16(1),
                       q16(5), q16(6), q16(1)));
    send_triangle(tri9(-32'sd1, -32'sd1, q16(1), q16(1), 0, q16(1), 0, q16(1), q16(1)));
    // field extremes
    send_triangle(tri9(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_triangle(tri9(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send_triangle(tri9(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_triangle(tri9(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                       32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    send_triangle(tri9(32'hFFFFFFFF, 0, 32'h00000001, 0, 32'hFFFFFFFF, 32'h00000001,
                       32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF));

    // extreme ray and the largest threshold
    set_ray(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'hFFFFFFFF);
    send_triangle(tri9(q16(-1), q16(-1), q16(2), q16(2), q16(-1), q16(2),
                       q16(-1), q16(2), q16(2)));
    repeat (100) send_triangle(random_triangle());

    // threshold zero with a degenerate triangle, direction -z
    set_ray(0, 0, 0, 0, 0, q16(-1), 0);
    send_triangle(tri9(q16(1), q16(1), q16(1), q16(1), q16(1), q16(1),
                       q16(1), q16(1), q16(1)));
    send_triangle(tri9(q16(-1), q16(-1), q16(-2), q16(2), q16(-1), q16(-2),
                       q16(-1), q16(2), q16(-2)));
    hold_req = 1'b1;
    repeat (300) send_triangle(random_triangle());

    repeat (4) random_phase(280);

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("ray_triangle_intersect_unit_test: clean");
    end else begin
      $display("ray_triangle_intersect_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rti_pkg.sv
rtl/core/rti_mul.sv
rtl/core/rti_delay.sv
rtl/core/rti_div.sv
rtl/core/ray_triangle_intersect_unit.sv
rtl/core/rti_checker.sv
sim/ray_triangle_intersect_checker.sv
sim/ray_triangle_intersect_unit_test.sv
